[hw/rtl/idpc_pkg.sv]
// ============================================================================
// idpc_pkg
// Shared types, codes and helper functions for the debounced input block.
// ============================================================================
package idpc_pkg;

    // Default number of input channels
    localparam int CHANNELS_DEFAULT = 8;

    // Most results sent for one tick transaction
    localparam int MAX_RESULTS = 8;

    // Reset values of the configuration registers
    localparam logic [7:0] SHORT_THRESHOLD_RESET = 8'd5;
    localparam logic [7:0] LONG_THRESHOLD_RESET  = 8'd100;

    // Configuration register indexes
    localparam logic CFG_SHORT_THRESHOLD = 1'b0;
    localparam logic CFG_LONG_THRESHOLD  = 1'b1;

    // Bit positions of the internal flag word
    localparam int FL_REV  = 0;
    localparam int FL_DOOR = 1;
    localparam int FL_OFF  = 2;
    localparam int FL_ON   = 3;
    localparam int FL_BTN  = 4;

    // Bits of the flag byte as seen in the register map
    localparam logic [7:0] FB_REV  = 8'h02;
    localparam logic [7:0] FB_DOOR = 8'h10;
    localparam logic [7:0] FB_OFF  = 8'h20;
    localparam logic [7:0] FB_ON   = 8'h40;
    localparam logic [7:0] FB_BTN  = 8'h80;

    // Reply data for a write past the register map
    localparam logic [7:0] BAD_WRITE_REPLY = 8'hFF;

    typedef logic [4:0] flags_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        EV_ON     = 3'd0,
        EV_OFF    = 3'd1,
        EV_OPENED = 3'd2,
        EV_CLOSED = 3'd3,
        EV_BUTTON = 3'd4
    } event_type_t;

    typedef enum logic [2:0] {
        RGN_STATUS,
        RGN_FLAGS,
        RGN_ZONE,
        RGN_SUBZONE,
        RGN_NONE
    } region_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FLUSH,
        ST_REG
    } state_t;

    // One result item as held in the output and pending registers
    typedef struct packed {
        result_kind_t kind;
        logic [2:0]   channel;
        event_type_t  event_type;
        logic         long_press;
        logic [7:0]   zone;
        logic [7:0]   subzone;
        logic [7:0]   read_data;
        logic         last;
    } result_t;

    function automatic logic [7:0] flags_to_byte(input flags_t f);
        logic [7:0] b;
        b = 8'h00;
        if (f[FL_REV])  b = b | FB_REV;
        if (f[FL_DOOR]) b = b | FB_DOOR;
        if (f[FL_OFF])  b = b | FB_OFF;
        if (f[FL_ON])   b = b | FB_ON;
        if (f[FL_BTN])  b = b | FB_BTN;
        return b;
    endfunction

    function automatic flags_t byte_to_flags(input logic [7:0] b);
        flags_t f;
        f = '0;
        f[FL_REV]  = |(b & FB_REV);
        f[FL_DOOR] = |(b & FB_DOOR);
        f[FL_OFF]  = |(b & FB_OFF);
        f[FL_ON]   = |(b & FB_ON);
        f[FL_BTN]  = |(b & FB_BTN);
        return f;
    endfunction

endpackage

[hw/rtl/input_debounce_press_classifier.sv]
// ============================================================================
// input_debounce_press_classifier
// Debounced input channels with on/off and short/long press events, plus a
// small register map for status, flags, zones and subzones.
// ============================================================================
//
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: action; tdata: pins, address,
//                                         write_data
// m_*       out        m_tvalid/m_tready  tuser: result_kind; tdata: channel,
//                                         event_type, long_press, zone,
//                                         subzone, read_data; tlast: last
// cfg_*     in         cfg_we             cfg_index, cfg_data
//
// A tick transaction is accepted while idle, then walks the channels one at a
// time through the shared debounce unit, then sends the held final event, if
// any. A register read or write is accepted, then answered. A full output
// register stalls the channel walk only on a channel that raises an event.
// Reset clears all channel state, the tables and the thresholds to defaults;
// there is no clearing pass. The input side is ready only while idle.
//
module input_debounce_press_classifier #(
    parameter int CHANNELS = idpc_pkg::CHANNELS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] pins, [14:8] address, [22:15] write_data, [23] zero
    input  logic [23:0] s_tdata,
    // [1:0] action
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] channel, [5:3] event_type, [6] long_press, [14:7] zone,
    // [22:15] subzone, [30:23] read_data, [31] zero
    output logic [31:0] m_tdata,
    // [1:0] result_kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] BASE_FLAGS   = 7'(CHANNELS);
    localparam logic [6:0] BASE_ZONE    = 7'(2 * CHANNELS);
    localparam logic [6:0] BASE_SUBZONE = 7'(3 * CHANNELS);
    localparam logic [6:0] MAP_END      = 7'(4 * CHANNELS);
    localparam logic [CW-1:0] LAST_IDX  = CW'(CHANNELS - 1);
    localparam logic [3:0] MAX_RES      = 4'(idpc_pkg::MAX_RESULTS);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    idpc_pkg::state_t    state_reg, state_next;
    idpc_pkg::region_t   region_reg;
    idpc_pkg::action_t   action_reg;
    logic [CW-1:0]       idx_reg;
    logic [7:0]          pins_reg;
    logic [7:0]          wdata_reg;
    logic [3:0]          evt_cnt_reg;
    logic [7:0]          short_reg;
    logic [7:0]          long_reg;
    logic                pend_valid_reg;
    idpc_pkg::result_t   pend_reg;
    logic                out_valid_reg;
    idpc_pkg::result_t   out_reg;

    logic                on_arr     [CHANNELS];
    logic [7:0]          cnt_arr    [CHANNELS];
    idpc_pkg::flags_t    flag_arr   [CHANNELS];
    logic [7:0]          zone_arr   [CHANNELS];
    logic [7:0]          subzone_arr[CHANNELS];

    // ------------------------------------------------------------------
    // Input field unpacking and address decode
    // ------------------------------------------------------------------
    logic [7:0]        in_pins;
    logic [6:0]        in_addr;
    logic [7:0]        in_wdata;
    idpc_pkg::region_t dec_region;
    logic [6:0]        dec_base;

    assign in_pins  = s_tdata[7:0];
    assign in_addr  = s_tdata[14:8];
    assign in_wdata = s_tdata[22:15];

    always_comb
    begin
        if (in_addr < BASE_FLAGS)
        begin
            dec_region = idpc_pkg::RGN_STATUS;
            dec_base   = 7'd0;
        end
        else if (in_addr < BASE_ZONE)
        begin
            dec_region = idpc_pkg::RGN_FLAGS;
            dec_base   = BASE_FLAGS;
        end
        else if (in_addr < BASE_SUBZONE)
        begin
            dec_region = idpc_pkg::RGN_ZONE;
            dec_base   = BASE_ZONE;
        end
        else if (in_addr < MAP_END)
        begin
            dec_region = idpc_pkg::RGN_SUBZONE;
            dec_base   = BASE_SUBZONE;
        end
        else
        begin
            dec_region = idpc_pkg::RGN_NONE;
            dec_base   = 7'd0;
        end
    end

    // Channels above the pin byte read as a high pin (inactive unless reversed).
    logic [CHANNELS-1:0] pin_vec;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_pin
        if (g < 8)
        begin : g_real
            assign pin_vec[g] = pins_reg[g];
        end
        else
        begin : g_none
            assign pin_vec[g] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Shared debounce unit: works on the channel selected by idx_reg
    // ------------------------------------------------------------------
    logic                   cur_on;
    logic [7:0]             cur_cnt;
    idpc_pkg::flags_t       cur_flags;
    logic                   act;
    logic [7:0]             cnt_inc;
    logic [7:0]             cnt_new;
    logic                   on_new;
    logic                   hit;
    idpc_pkg::event_type_t  ev;
    logic                   lp;
    logic                   send;
    logic                   out_free;
    logic                   stall;

    assign cur_on    = on_arr[idx_reg];
    assign cur_cnt   = cnt_arr[idx_reg];
    assign cur_flags = flag_arr[idx_reg];
    assign act       = (~pin_vec[idx_reg]) ^ cur_flags[idpc_pkg::FL_REV];
    assign cnt_inc   = cur_cnt + 8'd1;

    always_comb
    begin
        cnt_new = cur_cnt;
        on_new  = cur_on;
        hit     = 1'b0;
        ev      = idpc_pkg::EV_ON;
        lp      = 1'b0;
        if (!cur_on)
        begin
            // Waiting for a stable active level
            if (act)
            begin
                cnt_new = cnt_inc;
                if (cur_cnt == short_reg)
                begin
                    hit    = cur_flags[idpc_pkg::FL_ON];
                    ev     = cur_flags[idpc_pkg::FL_DOOR] ? idpc_pkg::EV_OPENED
                                                          : idpc_pkg::EV_ON;
                    on_new = 1'b1;
                end
            end
            else
            begin
                cnt_new = 8'd0;
            end
        end
        else if (cur_cnt > short_reg)
        begin
            // Press is past the short threshold: release or long hold
            if (!act)
            begin
                hit     = cur_flags[idpc_pkg::FL_BTN];
                ev      = idpc_pkg::EV_BUTTON;
                lp      = (cur_cnt >= long_reg);
                cnt_new = 8'd0;
            end
            else
            begin
                cnt_new = cnt_inc;
                if (cur_cnt == long_reg)
                begin
                    hit     = cur_flags[idpc_pkg::FL_BTN];
                    ev      = idpc_pkg::EV_BUTTON;
                    lp      = (cnt_inc >= long_reg);
                    cnt_new = 8'd0;
                end
            end
        end
        else if (act)
        begin
            cnt_new = 8'd0;
        end
        else
        begin
            // Counting a stable inactive level toward off
            cnt_new = cnt_inc;
            if (cur_cnt == short_reg)
            begin
                hit    = cur_flags[idpc_pkg::FL_OFF];
                ev     = cur_flags[idpc_pkg::FL_DOOR] ? idpc_pkg::EV_CLOSED
                                                      : idpc_pkg::EV_OFF;
                on_new = 1'b0;
            end
        end
    end

    assign send     = hit && (evt_cnt_reg < MAX_RES);
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = send && pend_valid_reg && !out_free;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            idpc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == idpc_pkg::ACT_TICK)
                        state_next = idpc_pkg::ST_TICK;
                    else if (s_tuser == idpc_pkg::ACT_READ ||
                             s_tuser == idpc_pkg::ACT_WRITE)
                        state_next = idpc_pkg::ST_REG;
                end
            end
            idpc_pkg::ST_TICK:
            begin
                if (!stall && idx_reg == LAST_IDX)
                    state_next = idpc_pkg::ST_FLUSH;
            end
            idpc_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                    state_next = idpc_pkg::ST_IDLE;
            end
            idpc_pkg::ST_REG:
            begin
                if (out_free)
                    state_next = idpc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = idpc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs
    // ------------------------------------------------------------------
    logic in_take;
    logic step_go;
    logic push_pend;
    logic flush_load;
    logic reg_load;
    logic load_out;

    always_comb
    begin
        in_take    = 1'b0;
        step_go    = 1'b0;
        push_pend  = 1'b0;
        flush_load = 1'b0;
        reg_load   = 1'b0;
        unique case (state_reg)
            idpc_pkg::ST_IDLE:  in_take    = s_tvalid;
            idpc_pkg::ST_TICK:
            begin
                step_go   = !stall;
                push_pend = !stall && send && pend_valid_reg;
            end
            idpc_pkg::ST_FLUSH: flush_load = pend_valid_reg && out_free;
            idpc_pkg::ST_REG:   reg_load   = out_free;
            default:
            begin
                in_take = 1'b0;
            end
        endcase
    end

    assign load_out = push_pend || flush_load || reg_load;
    assign s_tready = (state_reg == idpc_pkg::ST_IDLE);

    // ------------------------------------------------------------------
    // Register access reply
    // ------------------------------------------------------------------
    logic              reg_is_write;
    logic [7:0]        reg_rdata;
    idpc_pkg::result_t reply;
    idpc_pkg::result_t new_event;
    idpc_pkg::result_t flush_event;

    assign reg_is_write = (action_reg == idpc_pkg::ACT_WRITE);

    always_comb
    begin
        if (reg_is_write)
        begin
            reg_rdata = (region_reg == idpc_pkg::RGN_NONE) ? idpc_pkg::BAD_WRITE_REPLY
                                                           : wdata_reg;
        end
        else
        begin
            case (region_reg)
                idpc_pkg::RGN_STATUS:  reg_rdata = {7'd0, cur_on};
                idpc_pkg::RGN_FLAGS:   reg_rdata = idpc_pkg::flags_to_byte(cur_flags);
                idpc_pkg::RGN_ZONE:    reg_rdata = zone_arr[idx_reg];
                idpc_pkg::RGN_SUBZONE: reg_rdata = subzone_arr[idx_reg];
                default:               reg_rdata = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        reply            = '0;
        reply.kind       = reg_is_write ? idpc_pkg::KIND_WRITE : idpc_pkg::KIND_READ;
        reply.read_data  = reg_rdata;
        reply.last       = 1'b1;

        new_event            = '0;
        new_event.kind       = idpc_pkg::KIND_EVENT;
        new_event.channel    = 3'(idx_reg);
        new_event.event_type = ev;
        new_event.long_press = lp;
        new_event.zone       = zone_arr[idx_reg];
        new_event.subzone    = subzone_arr[idx_reg];

        // The event held back to the end of a tick closes the transaction.
        flush_event      = pend_reg;
        flush_event.last = 1'b1;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= idpc_pkg::ST_IDLE;
            idx_reg        <= '0;
            evt_cnt_reg    <= 4'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            short_reg      <= idpc_pkg::SHORT_THRESHOLD_RESET;
            long_reg       <= idpc_pkg::LONG_THRESHOLD_RESET;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_we)
            begin
                if (cfg_index == idpc_pkg::CFG_SHORT_THRESHOLD)
                    short_reg <= cfg_data;
                else
                    long_reg <= cfg_data;
            end

            // Start of a transaction
            if (in_take)
            begin
                idx_reg        <= (s_tuser == idpc_pkg::ACT_TICK) ? '0
                                                                  : CW'(in_addr - dec_base);
                evt_cnt_reg    <= 4'd0;
                pend_valid_reg <= 1'b0;
            end

            // Channel walk
            if (step_go)
            begin
                if (idx_reg != LAST_IDX)
                    idx_reg <= idx_reg + 1'b1;
                if (send)
                begin
                    pend_valid_reg <= 1'b1;
                    evt_cnt_reg    <= evt_cnt_reg + 4'd1;
                end
            end

            if (flush_load)
                pend_valid_reg <= 1'b0;

            // Output register valid
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= idpc_pkg::action_t'(s_tuser);
            region_reg <= dec_region;
            pins_reg   <= in_pins;
            wdata_reg  <= in_wdata;
        end

        if (step_go && send)
            pend_reg <= new_event;

        if (push_pend)
            out_reg <= pend_reg;
        else if (flush_load)
            out_reg <= flush_event;
        else if (reg_load)
            out_reg <= reply;
    end

    // ------------------------------------------------------------------
    // Channel tables
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                on_arr[i]      <= 1'b0;
                cnt_arr[i]     <= 8'd0;
                flag_arr[i]    <= '0;
                zone_arr[i]    <= 8'd0;
                subzone_arr[i] <= 8'd0;
            end
        end
        else if (step_go)
        begin
            on_arr[idx_reg]  <= on_new;
            cnt_arr[idx_reg] <= cnt_new;
        end
        else if (reg_load && reg_is_write)
        begin
            case (region_reg)
                idpc_pkg::RGN_FLAGS:
                begin
                    flag_arr[idx_reg] <= idpc_pkg::byte_to_flags(wdata_reg);
                    cnt_arr[idx_reg]  <= 8'd0;
                end
                idpc_pkg::RGN_ZONE:    zone_arr[idx_reg]    <= wdata_reg;
                idpc_pkg::RGN_SUBZONE: subzone_arr[idx_reg] <= wdata_reg;
                default:
                begin
                    // Status is read only; writes past the map change nothing.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output packing
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.read_data, out_reg.subzone, out_reg.zone,
                       out_reg.long_press, out_reg.event_type, out_reg.channel};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_tready))
        else $error("output register loaded while still holding a result");

    a_event_limit: assert property (@(posedge clk) disable iff (!rst_n)
        evt_cnt_reg <= MAX_RES)
        else $error("more events counted than allowed per tick");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == idpc_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("pending event left behind at end of tick");

    a_flush_sends_last: assert property (@(posedge clk) disable iff (!rst_n)
        flush_load |=> (m_tvalid && m_tlast))
        else $error("final event of a tick not marked last");

endmodule
